/* sv/vcfa_pkg.sv */
package vcfa_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_TEXT_MODE      = 3'd0;
    localparam logic [2:0] CFG_EIGHTY_COLUMNS = 3'd1;
    localparam logic [2:0] CFG_HIGH_RES       = 3'd2;
    localparam logic [2:0] CFG_DOUBLE_RES     = 3'd3;
    localparam logic [2:0] CFG_SECOND_PAGE    = 3'd4;
    localparam logic [2:0] CFG_MIXED_TEXT     = 3'd5;

    // Cell kinds
    localparam logic [1:0] KIND_TEXT   = 2'd0;
    localparam logic [1:0] KIND_LORES  = 2'd1;
    localparam logic [1:0] KIND_HIRES  = 2'd2;
    localparam logic [1:0] KIND_DHIRES = 2'd3;

    // Memory map
    localparam logic [15:0] TEXT_BASE  = 16'h0400;
    localparam logic [15:0] HIRES_BASE = 16'h2000;
    localparam logic [15:0] LINE_STEP  = 16'h0400;
    localparam logic [2:0]  LAST_LINE  = 3'd7;

    localparam logic [4:0] ROW_LIMIT   = 5'd24;
    localparam logic [4:0] MIXED_ROW   = 5'd20;
    localparam logic [6:0] WIDTH_40    = 7'd40;
    localparam logic [6:0] WIDTH_80    = 7'd80;

    // Video mode switches
    typedef struct packed {
        logic text_mode;
        logic eighty_columns;
        logic high_res;
        logic double_res;
        logic second_page;
        logic mixed_text;
    } vcfa_mode_t;

    // Fetch plan for one cell
    typedef struct packed {
        logic        valid;
        logic [15:0] base;
        logic        aux;
        logic [1:0]  kind;
        logic        multi;
    } vcfa_plan_t;

endpackage

/* sv/vcfa_decode.sv */
module vcfa_decode
    import vcfa_pkg::*;
(
    input  vcfa_mode_t mode,
    input  logic [4:0] cell_row,
    input  logic [6:0] cell_col,
    output vcfa_plan_t plan
);

    logic        wide;
    logic        in_range;
    logic        as_text;
    logic [6:0]  off;
    logic [9:0]  row_off;
    logic [9:0]  band_off;
    logic [15:0] text_addr;
    logic [15:0] hires_addr;
    logic        even_col;

    // Interleave: (row mod 8) * 0x80 + (row div 8) * 0x28
    assign band_off = {3'd0, cell_row[4:3], 5'd0} + {5'd0, cell_row[4:3], 3'd0};
    assign row_off  = {cell_row[2:0], 7'd0} + band_off;

    assign wide     = mode.eighty_columns;
    assign even_col = ~cell_col[0];
    assign off      = wide ? {1'b0, cell_col[6:1]} : cell_col;
    assign in_range = (cell_row < ROW_LIMIT) && (cell_col < (wide ? WIDTH_80 : WIDTH_40));
    assign as_text  = mode.text_mode || (mode.mixed_text && (cell_row >= MIXED_ROW));

    // Page 2 only counts in 40-column layouts
    assign text_addr  = TEXT_BASE + {6'd0, row_off} + {9'd0, off}
                      + ((!wide && mode.second_page) ? LINE_STEP : 16'h0000);
    assign hires_addr = HIRES_BASE + {6'd0, row_off} + {9'd0, off}
                      + ((!wide && mode.second_page) ? HIRES_BASE : 16'h0000);

    always_comb begin
        plan.valid = in_range;
        plan.base  = text_addr;
        plan.aux   = wide && even_col;
        plan.kind  = KIND_TEXT;
        plan.multi = 1'b0;
        if (as_text) begin
            plan.kind = KIND_TEXT;
        end else if (!mode.high_res) begin
            plan.kind = KIND_LORES;
            if (wide && !mode.double_res) begin
                plan.aux = 1'b0;
            end
        end else begin
            plan.base  = hires_addr;
            plan.multi = 1'b1;
            if (wide && mode.double_res) begin
                plan.kind = KIND_DHIRES;
            end else begin
                plan.kind = KIND_HIRES;
                plan.aux  = 1'b0;
                // single high-res in 80 columns: odd columns show nothing
                if (wide && !even_col) begin
                    plan.valid = 1'b0;
                end
            end
        end
    end

endmodule

/* sv/video_cell_fetch_address.sv */
// The first fetch of a cell is valid once the cell has passed the decode register
// and then the fetch register; a busy emitter holds it in the decode register.
// Throughput: one cell per cycle for text and low-res cells (one fetch each) while
// m_axis_tready is high; high-res cells hold the fetch emitter for line fetches 0 to 7,
// one line fetch a cycle. Cells that need no fetch are dropped in the decode stage.
// Reset: synchronous active-low aresetn clears all mode switches to 0 and
// empties both pipeline stages.
module video_cell_fetch_address
    import vcfa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic        cfg_wdata,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [4:0] cell_row, [11:5] cell_col, [15:12] zero

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [15:0] fetch_address, [18:16] line_index, rest zero
    output logic [2:0]  m_axis_tuser,   // [0] aux_bank, [2:1] cell_kind
    output logic        m_axis_tlast    // last_fetch
);

    vcfa_mode_t  mode_reg;
    vcfa_plan_t  plan;

    logic        d_valid_reg;
    vcfa_plan_t  d_plan_reg;

    logic        o_valid_reg;
    logic [15:0] o_addr_reg;
    logic        o_aux_reg;
    logic [1:0]  o_kind_reg;
    logic [2:0]  o_line_reg;
    logic        o_multi_reg;

    logic        o_last;
    logic        o_done;
    logic        e_free;
    logic        s_accept;
    logic        d_move;

    // Mode switch registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_TEXT_MODE:      mode_reg.text_mode      <= cfg_wdata;
                CFG_EIGHTY_COLUMNS: mode_reg.eighty_columns <= cfg_wdata;
                CFG_HIGH_RES:       mode_reg.high_res       <= cfg_wdata;
                CFG_DOUBLE_RES:     mode_reg.double_res     <= cfg_wdata;
                CFG_SECOND_PAGE:    mode_reg.second_page    <= cfg_wdata;
                CFG_MIXED_TEXT:     mode_reg.mixed_text     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    vcfa_decode u_decode (
        .mode     (mode_reg),
        .cell_row (s_axis_tdata[4:0]),
        .cell_col (s_axis_tdata[11:5]),
        .plan     (plan)
    );

    // Handshake control
    assign o_last        = !o_multi_reg || (o_line_reg == LAST_LINE);
    assign o_done        = o_valid_reg && m_axis_tready && o_last;
    assign e_free        = !o_valid_reg || o_done;
    assign d_move        = d_valid_reg && e_free;
    assign s_axis_tready = !d_valid_reg || e_free;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // Decode stage: keeps only cells that produce fetches
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (s_accept) begin
            d_valid_reg <= plan.valid;
        end else if (d_move) begin
            d_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            d_plan_reg <= plan;
        end
    end

    // Fetch emitter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (d_move) begin
            o_valid_reg <= 1'b1;
        end else if (o_done) begin
            o_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (d_move) begin
            o_addr_reg  <= d_plan_reg.base;
            o_aux_reg   <= d_plan_reg.aux;
            o_kind_reg  <= d_plan_reg.kind;
            o_multi_reg <= d_plan_reg.multi;
            o_line_reg  <= 3'd0;
        end else if (o_valid_reg && m_axis_tready && !o_last) begin
            o_addr_reg <= o_addr_reg + LINE_STEP;
            o_line_reg <= o_line_reg + 3'd1;
        end
    end

    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tdata  = {5'd0, o_line_reg, o_addr_reg};
    assign m_axis_tuser  = {o_kind_reg, o_aux_reg};
    assign m_axis_tlast  = o_last;

endmodule

/* sv/vcfa_checker.sv */
module vcfa_checker
    import vcfa_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // Stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled fetch changed");

    // Text and low-res cells give exactly one fetch at line 0
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser[2:1] == KIND_TEXT || m_axis_tuser[2:1] == KIND_LORES)
            |-> m_axis_tlast && (m_axis_tdata[18:16] == 3'd0))
        else $error("single fetch cell malformed");

    // High-res burst ends on the last line
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tlast
            && (m_axis_tuser[2:1] == KIND_HIRES || m_axis_tuser[2:1] == KIND_DHIRES)
            |-> m_axis_tdata[18:16] == LAST_LINE)
        else $error("high-res burst ended early");

    // Within a burst, each line steps the address and keeps bank and kind
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid
            && (m_axis_tdata[15:0] == 16'($past(m_axis_tdata[15:0]) + LINE_STEP))
            && (m_axis_tdata[18:16] == 3'($past(m_axis_tdata[18:16]) + 3'd1))
            && $stable(m_axis_tuser))
        else $error("burst line step wrong");

endmodule

bind video_cell_fetch_address vcfa_checker u_vcfa_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
